FILE: src/vcfc_pkg.sv
// ----------------------------------------------------------------------------
// vcfc_pkg
// Shared types, constants and helpers of the voxel chunk face culler.
// ----------------------------------------------------------------------------
package vcfc_pkg;

  // Chunk geometry
  localparam int unsigned SIDE   = 16;
  localparam int unsigned VOLUME = SIDE * SIDE * SIDE;
  localparam int unsigned AW     = $clog2(VOLUME);

  // Field widths
  localparam int unsigned CW     = 4;   // coordinate
  localparam int unsigned TW     = 8;   // voxel type
  localparam int unsigned DW     = 3;   // face direction
  localparam int unsigned CNT_W  = 17;  // face counter
  localparam int unsigned NDIR   = 6;

  localparam logic [CNT_W-1:0] VERTS_PER_FACE = CNT_W'(4);
  localparam logic [TW-1:0]    RESET_TYPE     = TW'(1);

  // Request kinds
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FACES = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  // One result word
  typedef struct packed {
    logic [CW-1:0]    x;
    logic [CW-1:0]    y;
    logic [CW-1:0]    z;
    logic [DW-1:0]    dir;
    logic             face_valid;
    logic [CNT_W-1:0] vertex_base;
    logic [TW-1:0]    voxel_type;
    logic             last;
  } res_t;

  // Neighbour lookup result
  typedef struct packed {
    logic          in_bounds;
    logic [AW-1:0] addr;
  } nbr_t;

  // Linear address: x + z*SIDE + y*SIDE^2
  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] x, logic [CW-1:0] y,
                                            logic [CW-1:0] z);
    logic [31:0] a;
    a = 32'(x) + 32'(z) * SIDE + 32'(y) * SIDE * SIDE;
    return a[AW-1:0];
  endfunction

  function automatic logic in_chunk(logic [CW-1:0] x, logic [CW-1:0] y,
                                    logic [CW-1:0] z);
    return (32'(x) < SIDE) && (32'(y) < SIDE) && (32'(z) < SIDE);
  endfunction

  // Neighbour of a voxel in direction x-, x+, y-, y+, z-, z+
  function automatic nbr_t nbr_of(logic [DW-1:0] dir, logic [CW-1:0] x,
                                  logic [CW-1:0] y, logic [CW-1:0] z);
    nbr_t          n;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [CW-1:0] nz;
    logic          ok;
    nx = x;
    ny = y;
    nz = z;
    ok = 1'b0;
    case (dir)
      3'd0: begin ok = (x != '0);            nx = x - CW'(1); end
      3'd1: begin ok = (32'(x) + 1 < SIDE);  nx = x + CW'(1); end
      3'd2: begin ok = (y != '0);            ny = y - CW'(1); end
      3'd3: begin ok = (32'(y) + 1 < SIDE);  ny = y + CW'(1); end
      3'd4: begin ok = (z != '0);            nz = z - CW'(1); end
      3'd5: begin ok = (32'(z) + 1 < SIDE);  nz = z + CW'(1); end
      default: ok = 1'b0;
    endcase
    n.in_bounds = ok && in_chunk(nx, ny, nz);
    n.addr      = addr_of(nx, ny, nz);
    return n;
  endfunction

endpackage

FILE: src/vcfc_ram.sv
// ----------------------------------------------------------------------------
// vcfc_ram
// Generic single-write, single-read synchronous RAM; read data registered
// and held while no read is requested.
// ----------------------------------------------------------------------------
module vcfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/vcfc_seq.sv
// ----------------------------------------------------------------------------
// vcfc_seq
// Request sequencer: clearing pass, voxel store access, neighbour scan and
// face emission with the face counter.
// ----------------------------------------------------------------------------
module vcfc_seq
  import vcfc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  // request side
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  req_e          req_type_i,
  input  logic [CW-1:0] pos_x_i,
  input  logic [CW-1:0] pos_y_i,
  input  logic [CW-1:0] pos_z_i,
  input  logic [TW-1:0] wr_type_i,
  // result side
  input  logic          res_free_i,
  output logic          res_push_o,
  output res_t          res_o
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_EMIT   = 5'b01000,
    ST_SINGLE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  req_e             req_q, req_d;
  logic [CW-1:0]    x_q, x_d, y_q, y_d, z_q, z_d;
  logic [TW-1:0]    type_q, type_d;
  logic [2:0]       step_q, step_d;
  logic             rd_in_q, rd_in_d;
  logic [NDIR-1:0]  mask_q, mask_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [TW-1:0]    ram_wdata, ram_rdata;

  logic [TW-1:0]    cur_type;
  nbr_t             nb;
  logic [NDIR-1:0]  low_bit, rest;
  logic [DW-1:0]    low_dir;

  vcfc_ram #(
    .WIDTH (TW),
    .DEPTH (VOLUME)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Type returned by the last read; outside the chunk reads as empty
  assign cur_type = rd_in_q ? ram_rdata : '0;

  // Lowest pending face direction
  assign low_bit = mask_q & (~mask_q + NDIR'(1));
  assign rest    = mask_q & ~low_bit;
  always_comb begin
    low_dir = '0;
    for (int i = NDIR - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        low_dir = DW'(i);
      end
    end
  end

  // Next neighbour to read: direction equals current step
  assign nb = nbr_of(step_q, x_q, y_q, z_q);

  // Control
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    req_d      = req_q;
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    type_d     = type_q;
    step_d     = step_q;
    rd_in_d    = rd_in_q;
    mask_d     = mask_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr_q;
    ram_wdata  = RESET_TYPE;
    ram_re     = 1'b0;
    ram_raddr  = nb.addr;
    req_ready_o = 1'b0;
    res_push_o = 1'b0;
    res_o.x           = x_q;
    res_o.y           = y_q;
    res_o.z           = z_q;
    res_o.dir         = '0;
    res_o.face_valid  = 1'b0;
    res_o.vertex_base = cnt_q;
    res_o.voxel_type  = type_q;
    res_o.last        = 1'b1;

    case (state_q)
      // sweep the store to the reset type
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_q == AW'(VOLUME - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d  = req_type_i;
          x_d    = pos_x_i;
          y_d    = pos_y_i;
          z_d    = pos_z_i;
          mask_d = '0;
          step_d = '0;
          if (req_type_i == REQ_WRITE) begin
            ram_we    = in_chunk(pos_x_i, pos_y_i, pos_z_i);
            ram_waddr = addr_of(pos_x_i, pos_y_i, pos_z_i);
            ram_wdata = wr_type_i;
            type_d    = in_chunk(pos_x_i, pos_y_i, pos_z_i) ? wr_type_i : '0;
            state_d   = ST_SINGLE;
          end else begin
            if (req_type_i == REQ_CLEAR) begin
              cnt_d = '0;
            end
            ram_re    = 1'b1;
            ram_raddr = addr_of(pos_x_i, pos_y_i, pos_z_i);
            rd_in_d   = in_chunk(pos_x_i, pos_y_i, pos_z_i);
            state_d   = ST_READ;
          end
        end
      end

      // one store read per cycle: centre, then six neighbours
      ST_READ: begin
        if (step_q == 3'd0) begin
          type_d = cur_type;
          if (req_q != REQ_FACES || cur_type == '0) begin
            state_d = ST_SINGLE;
          end else begin
            ram_re  = nb.in_bounds;
            rd_in_d = nb.in_bounds;
            step_d  = 3'd1;
          end
        end else begin
          mask_d[step_q - 3'd1] = (cur_type == '0);
          if (step_q == 3'(NDIR)) begin
            state_d = (mask_d == '0) ? ST_SINGLE : ST_EMIT;
          end else begin
            ram_re  = nb.in_bounds;
            rd_in_d = nb.in_bounds;
            step_d  = step_q + 3'd1;
          end
        end
      end

      // one face per free output slot
      ST_EMIT: begin
        res_o.dir        = low_dir;
        res_o.face_valid = 1'b1;
        res_o.last       = (rest == '0);
        if (res_free_i) begin
          res_push_o = 1'b1;
          cnt_d      = cnt_q + VERTS_PER_FACE;
          mask_d     = rest;
          if (rest == '0) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_SINGLE: begin
        if (res_free_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      cnt_q      <= '0;
      step_q     <= '0;
      rd_in_q    <= 1'b0;
      mask_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      cnt_q      <= cnt_d;
      step_q     <= step_d;
      rd_in_q    <= rd_in_d;
      mask_q     <= mask_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    type_q <= type_d;
  end

`ifndef SYNTHESIS
  // store is written only by the sweep or on taking a write request
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
    else $error("store written outside sweep or request acceptance");

  // a face is only emitted from a pending direction
  a_face_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.face_valid) |-> (mask_q != '0))
    else $error("face emitted with no pending direction");

  // each emitted face advances the counter by one face's vertices
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.face_valid) |=> (cnt_q == $past(cnt_q) + VERTS_PER_FACE))
    else $error("face counter did not advance");

  // the final word of a request frees the sequencer
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last) |=> (state_q == ST_IDLE))
    else $error("sequencer not idle after final word");
`endif

endmodule

FILE: src/voxel_chunk_face_culler.sv
// ----------------------------------------------------------------------------
// voxel_chunk_face_culler
// Voxel chunk store with per-voxel exposed face culling.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis takes one request word: tuser selects write, read, face query or
//    counter clear; tdata carries the voxel position and the type to write.
//  - m_axis returns one or more result words per request, tlast on the final
//    one; tuser flags words that carry a face.
//  - Write: accepted in idle, result word pushed from the single-word state.
//    Read, clear and empty voxel query: centre read, then the single-word state.
//    Face query: one store read per cycle for the centre and six neighbours,
//    then the first face word (or the word of a hidden voxel), then one face
//    word per cycle while the output register is free, up to 6; the single
//    store read port makes the reads sequential. A new request is taken once
//    the previous one has handed its last word to the output register.
//  - After reset the store is swept to type 1, one entry per cycle, while
//    s_axis_tready stays low; the face counter resets to zero.
//  - While m_axis_tready is low the output register holds its word and the
//    sequencer waits; a new request may still be accepted while a finished
//    word waits to be taken.
// ----------------------------------------------------------------------------
module voxel_chunk_face_culler
  import vcfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // pos_x, pos_y, pos_z, wr_type, zero pad
  input  logic [1:0]  s_axis_tuser,  // req_type
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_x, out_y, out_z, face_dir,
                                     // vertex_base, voxel_type
  output logic [0:0]  m_axis_tuser,  // face_valid
  output logic        m_axis_tlast
);

  logic res_push, res_free;
  res_t res, out_q;
  logic out_valid_q;

  vcfc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (req_e'(s_axis_tuser)),
    .pos_x_i     (s_axis_tdata[3:0]),
    .pos_y_i     (s_axis_tdata[7:4]),
    .pos_z_i     (s_axis_tdata[11:8]),
    .wr_type_i   (s_axis_tdata[19:12]),
    .res_free_i  (res_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // Output register
  assign res_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  // Word packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.voxel_type, out_q.vertex_base, out_q.dir,
                          out_q.z, out_q.y, out_q.x};
  assign m_axis_tuser  = out_q.face_valid;
  assign m_axis_tlast  = out_q.last;

endmodule
